// File: hw/rtl/tts_pkg.sv
// Shared types and constants for the touch tap/swipe classifier.
// Gesture codes, register indexes, configuration struct and reset values.
// No dependencies.
`default_nettype none

package tts_pkg;

  // Fixed widths of the configuration registers
  localparam int unsigned THR_BITS  = 12;
  localparam int unsigned TMAX_BITS = 32;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_IDX_BITS  = 2;

  typedef enum logic [1:0] {
    GEST_NONE  = 2'd0,
    GEST_LEFT  = 2'd1,
    GEST_RIGHT = 2'd2,
    GEST_TAP   = 2'd3
  } gesture_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLED        = 2'd0,
    REG_SWIPE_MIN      = 2'd1,
    REG_TAP_MAX_TRAVEL = 2'd2,
    REG_TAP_MAX_TIME   = 2'd3
  } reg_index_t;

  localparam logic [THR_BITS-1:0]  SWIPE_MIN_RST      = 12'd32;
  localparam logic [THR_BITS-1:0]  TAP_MAX_TRAVEL_RST = 12'd16;
  localparam logic [TMAX_BITS-1:0] TAP_MAX_TIME_RST   = 32'd700;

  typedef struct packed {
    logic                 enabled;
    logic [THR_BITS-1:0]  swipe_min_travel;
    logic [THR_BITS-1:0]  tap_max_travel;
    logic [TMAX_BITS-1:0] tap_max_time;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/tts_cfg_regs.sv
// Configuration register file of the touch classifier.
// Depends on tts_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module tts_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wen,
  input  wire logic [tts_pkg::CFG_IDX_BITS-1:0]   index,
  input  wire logic [tts_pkg::CFG_DATA_BITS-1:0]  wdata,
  output tts_pkg::cfg_t                           cfg
);
  import tts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled          <= 1'b0;
      cfg.swipe_min_travel <= SWIPE_MIN_RST;
      cfg.tap_max_travel   <= TAP_MAX_TRAVEL_RST;
      cfg.tap_max_time     <= TAP_MAX_TIME_RST;
    end else if (wen) begin
      case (reg_index_t'(index))
        REG_ENABLED:        cfg.enabled          <= wdata[0];
        REG_SWIPE_MIN:      cfg.swipe_min_travel <= wdata[THR_BITS-1:0];
        REG_TAP_MAX_TRAVEL: cfg.tap_max_travel   <= wdata[THR_BITS-1:0];
        REG_TAP_MAX_TIME:   cfg.tap_max_time     <= wdata[TMAX_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tts_classify.sv
// Combinational gesture decision for one touch sample against the press state.
// Depends on tts_pkg (cfg_t, gesture_t).
`default_nettype none

module tts_classify #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32
) (
  input  wire tts_pkg::cfg_t            cfg,
  input  wire logic                     sample_valid,
  input  wire logic                     finger_down,
  input  wire logic [COORD_BITS-1:0]    pos_x,
  input  wire logic [COORD_BITS-1:0]    pos_y,
  input  wire logic [TIME_BITS-1:0]     now_time,
  input  wire logic                     touching,
  input  wire logic [COORD_BITS-1:0]    start_x,
  input  wire logic [COORD_BITS-1:0]    start_y,
  input  wire logic [COORD_BITS-1:0]    last_x,
  input  wire logic [COORD_BITS-1:0]    last_y,
  input  wire logic [TIME_BITS-1:0]     press_time,
  output logic                          press_start,
  output logic                          last_upd,
  output logic                          press_end,
  output logic                          tap_hit,
  output tts_pkg::gesture_t             gesture
);
  import tts_pkg::*;

  localparam int unsigned CW = (COORD_BITS > THR_BITS) ? COORD_BITS : THR_BITS;
  localparam int unsigned TW = (TIME_BITS > TMAX_BITS) ? TIME_BITS : TMAX_BITS;

  logic                  act;
  logic [COORD_BITS-1:0] adx, ady;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  is_swipe, is_tap;

  always_comb begin
    act         = cfg.enabled & sample_valid;
    press_start = act & finger_down & ~touching;
    last_upd    = act & finger_down;
    press_end   = act & ~finger_down & touching;

    adx     = (last_x >= start_x) ? (last_x - start_x) : (start_x - last_x);
    ady     = (last_y >= start_y) ? (last_y - start_y) : (start_y - last_y);
    elapsed = now_time - press_time;   // wraps modulo 2^TIME_BITS

    is_swipe = (CW'(adx) >= CW'(cfg.swipe_min_travel)) && (adx > ady);
    is_tap   = (CW'(adx) <= CW'(cfg.tap_max_travel)) &&
               (CW'(ady) <= CW'(cfg.tap_max_travel)) &&
               (TW'(elapsed) <= TW'(cfg.tap_max_time));

    tap_hit = press_end & ~is_swipe & is_tap;
    gesture = GEST_NONE;
    if (press_end) begin
      if (is_swipe) begin
        gesture = (last_x < start_x) ? GEST_LEFT : GEST_RIGHT;
      end else if (is_tap) begin
        gesture = GEST_TAP;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/touch_tap_swipe_classifier_unit.sv
// Top level of the touch tap/swipe classifier: stream ports, sample register,
// press state and result register. Depends on tts_pkg, tts_cfg_regs, tts_classify.
//
//   channel   | dir | words                                      | handshake
//   ----------+-----+--------------------------------------------+----------------
//   s_*       | in  | one touch sample per word                  | tvalid/tready
//   m_*       | out | one gesture result per accepted sample     | tvalid/tready
//   cfg_*     | in  | register writes, index 0..3                | wen only
//
// One sample word per cycle, back to back, while m_tready stays high; each sample
// passes through the sample register, then the result register.
// Press state commits as a sample moves into the result register, so the next
// sample already sees it. With m_tready low the sample register takes one more
// word; s_tready drops only while both stages are full.
// Synchronous reset clears both stages, the press state and the registers.
`default_nettype none

module touch_tap_swipe_classifier_unit #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32,
  localparam int unsigned IN_BITS  = ((2 + 2*COORD_BITS + TIME_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = ((2 + 2*COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // s_tdata: sample_valid, finger_down, pos_x, pos_y, now_time, zero pad
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [IN_BITS-1:0]                 s_tdata,
  // m_tdata: gesture, tap_pos_x, tap_pos_y, zero pad
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [OUT_BITS-1:0]                     m_tdata,
  input  wire logic                               cfg_wen,
  input  wire logic [tts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tts_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import tts_pkg::*;

  localparam int unsigned X_LO = 2;
  localparam int unsigned Y_LO = X_LO + COORD_BITS;
  localparam int unsigned T_LO = Y_LO + COORD_BITS;

  cfg_t cfg;

  // sample register
  logic                  in_v;
  logic                  smp_valid, smp_down;
  logic [COORD_BITS-1:0] smp_x, smp_y;
  logic [TIME_BITS-1:0]  smp_time;

  // press state
  logic                  touching;
  logic [COORD_BITS-1:0] start_x, start_y, last_x, last_y, tap_x, tap_y;
  logic [TIME_BITS-1:0]  press_time;

  // result register
  logic                  out_v;
  gesture_t              res_gesture;
  logic [COORD_BITS-1:0] res_x, res_y;

  logic     advance;
  logic     press_start, last_upd, press_end, tap_hit;
  gesture_t gesture;

  tts_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wen   (cfg_wen),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  tts_classify #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_cls (
    .cfg          (cfg),
    .sample_valid (smp_valid),
    .finger_down  (smp_down),
    .pos_x        (smp_x),
    .pos_y        (smp_y),
    .now_time     (smp_time),
    .touching     (touching),
    .start_x      (start_x),
    .start_y      (start_y),
    .last_x       (last_x),
    .last_y       (last_y),
    .press_time   (press_time),
    .press_start  (press_start),
    .last_upd     (last_upd),
    .press_end    (press_end),
    .tap_hit      (tap_hit),
    .gesture      (gesture)
  );

  // sample moves on when the result register is empty or being drained
  assign advance  = in_v & (~out_v | m_tready);
  assign s_tready = ~in_v | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      smp_valid <= s_tdata[0];
      smp_down  <= s_tdata[1];
      smp_x     <= s_tdata[X_LO +: COORD_BITS];
      smp_y     <= s_tdata[Y_LO +: COORD_BITS];
      smp_time  <= s_tdata[T_LO +: TIME_BITS];
    end
  end

  // press state, committed as the sample leaves the sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      touching   <= 1'b0;
      start_x    <= '0;
      start_y    <= '0;
      last_x     <= '0;
      last_y     <= '0;
      press_time <= '0;
      tap_x      <= '0;
      tap_y      <= '0;
    end else if (advance) begin
      if (press_start) begin
        touching   <= 1'b1;
        start_x    <= smp_x;
        start_y    <= smp_y;
        press_time <= smp_time;
      end
      if (last_upd) begin
        last_x <= smp_x;
        last_y <= smp_y;
      end
      if (press_end) begin
        touching <= 1'b0;
      end
      if (tap_hit) begin
        tap_x <= last_x;
        tap_y <= last_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  // tap point shown is the one after this sample
  always_ff @(posedge clk) begin
    if (advance) begin
      res_gesture <= gesture;
      res_x       <= tap_hit ? last_x : tap_x;
      res_y       <= tap_hit ? last_y : tap_y;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = OUT_BITS'({res_y, res_x, res_gesture});

endmodule

`default_nettype wire

// File: hw/rtl/tts_checker.sv
// Port-level checks for the touch classifier, bound to the top level.
// Depends on tts_pkg (gesture codes) and touch_tap_swipe_classifier_unit ports.
`default_nettype none

module tts_checker #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned OUT_BITS   = 32
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tready,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [OUT_BITS-1:0] m_tdata
);
  import tts_pkg::*;

  localparam int unsigned PW = 2*COORD_BITS;

  logic [PW-1:0] seen_tap;
  logic [1:0]    out_gest;
  logic [PW-1:0] out_tap;

  assign out_gest = m_tdata[1:0];
  assign out_tap  = m_tdata[2 +: PW];

  // tap point of the last delivered word
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_tap <= '0;
    end else if (m_tvalid && m_tready) begin
      seen_tap <= out_tap;
    end
  end

  a_rst_out_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_rst_in_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_tap_only_on_tap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && out_gest != GEST_TAP |-> out_tap == seen_tap)
    else $error("tap point moved without a tap");

endmodule

bind touch_tap_swipe_classifier_unit tts_checker #(
  .COORD_BITS (COORD_BITS),
  .OUT_BITS   (OUT_BITS)
) u_tts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
